// ----- hdl/piqsc_pkg.sv -----
// Package for the packet ingress queue with sequence check.
// Holds request kinds, controller states, field widths and parameter defaults.
// No dependencies.
package piqsc_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_NUM_GROUPS  = 8;

    localparam int HANDLE_W = 16;
    localparam int ID_W     = 8;
    localparam int GROUP_W  = 8;
    localparam int SEQ_W    = 16;
    localparam int KIND_W   = 2;

    localparam logic [ID_W-1:0] HOST_ID_RESET = 8'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ARRIVE = 2'd0,
        KIND_GET    = 2'd1,
        KIND_SET    = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

// ----- hdl/packet_ingress_queue_seq_check_core.sv -----
// Packet ingress queue with per-group sequence check, top level.
// Depends on piqsc_pkg.
//
// Usage:
//   Requests enter on s_axis: tuser holds the kind (arrive, get, set group
//   count, clear), tdata the packet handle, destination, group and sequence.
//   Every request gives exactly one result on m_axis: tuser is the "get
//   returned a packet" flag, tdata holds the handle, check flags, expected
//   count, waiting flag and fill count.
//   cfg_wr_en/cfg_wr_data write the host destination id; write only while idle.
// Operation:
//   The accept cycle issues the reads of the handle memory (at the head) and of
//   the group count memory; in the execute state, once the output register is
//   free, the block does the read-modify-write and loads the output register.
//   The read-then-commit sequence of the two memory ports means a new request
//   is taken only after the previous one has committed.
// Reset:
//   Queue empty, all group counts unset (per-group valid bits), host id 1.
// Stall:
//   A held result does not block acceptance; the commit waits until the output
//   register is free, and no new request is taken until it commits.
module packet_ingress_queue_seq_check_core #(
    parameter int QUEUE_DEPTH = piqsc_pkg::DEF_QUEUE_DEPTH,
    parameter int NUM_GROUPS  = piqsc_pkg::DEF_NUM_GROUPS,
    localparam int CW  = $clog2(QUEUE_DEPTH + 1),
    localparam int OW  = ((36 + CW + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [piqsc_pkg::ID_W-1:0]    cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] pkt_handle, [23:16] pkt_dest, [31:24] pkt_group, [47:32] pkt_seq
    input  logic [47:0]                   s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] out_handle, [16] seq_error, [32:17] expected_seq, [33] illegal_group,
    // [34] queue_full_drop, [35] waiting, [35+CW:36] pending_count, rest zero
    output logic [OW-1:0]                 m_axis_tdata,
    // [0] out_valid
    output logic                          m_axis_tuser
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int GAW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int HW  = piqsc_pkg::HANDLE_W;
    localparam int SW  = piqsc_pkg::SEQ_W;

    piqsc_pkg::state_t state_reg, state_next;

    logic [piqsc_pkg::ID_W-1:0]    host_id_reg;
    piqsc_pkg::kind_t              kind_reg;
    logic [HW-1:0]                 handle_reg;
    logic [piqsc_pkg::ID_W-1:0]    dest_reg;
    logic [piqsc_pkg::GROUP_W-1:0] group_reg;
    logic [SW-1:0]                 seq_reg;

    logic [QAW-1:0]        head_reg, head_next;
    logic [QAW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [NUM_GROUPS-1:0] gvld_reg, gvld_next;

    logic [HW-1:0] q_mem [QUEUE_DEPTH];
    logic [SW-1:0] g_mem [NUM_GROUPS];
    logic [HW-1:0] q_rd_reg;
    logic [SW-1:0] g_rd_reg;

    logic          q_we;
    logic          g_we;
    logic          accept;
    logic          commit;
    logic          in_range;
    logic [SW-1:0] last_seq;
    logic [SW-1:0] expect_seq;

    logic          m_valid_reg;
    logic [OW-1:0] m_data_reg, m_data_next;
    logic          m_user_reg, m_user_next;

    logic          o_err, o_ill, o_drop;
    logic [SW-1:0] o_exp;
    logic [HW-1:0] o_handle;

    assign accept = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            piqsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = piqsc_pkg::ST_EXEC;
                end
            end
            piqsc_pkg::ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = piqsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = piqsc_pkg::ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
        case (state_reg)
            piqsc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            piqsc_pkg::ST_EXEC:
            begin
                commit = !m_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign in_range   = {1'b0, group_reg} < 9'(NUM_GROUPS);
    assign last_seq   = (in_range && gvld_reg[group_reg[GAW-1:0]]) ? g_rd_reg : '0;
    assign expect_seq = last_seq + SW'(1);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        gvld_next = gvld_reg;
        q_we      = 1'b0;
        g_we      = 1'b0;
        o_err     = 1'b0;
        o_ill     = 1'b0;
        o_drop    = 1'b0;
        o_exp     = '0;
        o_handle  = '0;
        m_user_next = 1'b0;
        case (kind_reg)
            piqsc_pkg::KIND_ARRIVE:
            begin
                if (dest_reg == host_id_reg)
                begin
                    if (in_range)
                    begin
                        o_exp = expect_seq;
                        o_err = (last_seq != '0) && (expect_seq != seq_reg);
                        g_we  = 1'b1;
                        gvld_next[group_reg[GAW-1:0]] = 1'b1;
                    end
                    else
                    begin
                        o_ill = 1'b1;
                    end
                end
                if (fill_reg < CW'(QUEUE_DEPTH))
                begin
                    q_we      = 1'b1;
                    tail_next = (tail_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + QAW'(1);
                    fill_next = fill_reg + CW'(1);
                end
                else
                begin
                    o_drop = 1'b1;
                end
            end
            piqsc_pkg::KIND_GET:
            begin
                if (fill_reg != '0)
                begin
                    m_user_next = 1'b1;
                    o_handle    = q_rd_reg;
                    head_next   = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QAW'(1);
                    fill_next   = fill_reg - CW'(1);
                end
            end
            piqsc_pkg::KIND_SET:
            begin
                if (in_range)
                begin
                    g_we = 1'b1;
                    gvld_next[group_reg[GAW-1:0]] = 1'b1;
                end
            end
            piqsc_pkg::KIND_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                fill_next = '0;
                gvld_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
        m_data_next = '0;
        m_data_next[15:0]         = o_handle;
        m_data_next[16]           = o_err;
        m_data_next[32:17]        = o_exp;
        m_data_next[33]           = o_ill;
        m_data_next[34]           = o_drop;
        m_data_next[35]           = (fill_next == '0);
        m_data_next[36+CW-1:36]   = fill_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= piqsc_pkg::ST_IDLE;
            host_id_reg <= piqsc_pkg::HOST_ID_RESET;
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            gvld_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                host_id_reg <= cfg_wr_data;
            end
            if (commit)
            begin
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                fill_reg    <= fill_next;
                gvld_reg    <= gvld_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= piqsc_pkg::kind_t'(s_axis_tuser);
            handle_reg <= s_axis_tdata[15:0];
            dest_reg   <= s_axis_tdata[23:16];
            group_reg  <= s_axis_tdata[31:24];
            seq_reg    <= s_axis_tdata[47:32];
        end
        if (commit)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    // handle queue memory: read at head on accept, write at tail on commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_rd_reg <= q_mem[head_reg];
        end
        if (commit && q_we)
        begin
            q_mem[tail_reg] <= handle_reg;
        end
    end

    // group count memory; unset entries are masked by gvld_reg
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            g_rd_reg <= g_mem[s_axis_tdata[24+GAW-1:24]];
        end
        if (commit && g_we)
        begin
            g_mem[group_reg[GAW-1:0]] <= seq_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == piqsc_pkg::ST_EXEC))
        else $error("accepted request not executed");

    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_valid_reg && (state_reg == piqsc_pkg::ST_IDLE))
        else $error("commit did not load result");

    a_wait_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_data_reg[35] == (m_data_reg[36+CW-1:36] == '0)))
        else $error("waiting flag disagrees with fill count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && m_user_next) |-> (fill_reg != '0) && (kind_reg == piqsc_pkg::KIND_GET))
        else $error("pop from empty queue");

endmodule
